// File: hdl/pfde_pkg.sv
// Shared types and codes for the page frame buffer draw engine.
// Holds the command codes, draw modes and the front-to-back command record.
// No dependencies.
package pfde_pkg;

	localparam logic [3:0] KIND_SET    = 4'd0;
	localparam logic [3:0] KIND_CLR    = 4'd1;
	localparam logic [3:0] KIND_HLINE  = 4'd2;
	localparam logic [3:0] KIND_VLINE  = 4'd3;
	localparam logic [3:0] KIND_RECT   = 4'd4;
	localparam logic [3:0] KIND_CLEAR  = 4'd5;
	localparam logic [3:0] KIND_CHECK  = 4'd6;
	localparam logic [3:0] KIND_WRITE  = 4'd7;
	localparam logic [3:0] KIND_READ   = 4'd8;

	localparam logic [1:0] MODE_CLR   = 2'd0;
	localparam logic [1:0] MODE_SET   = 2'd1;
	localparam logic [1:0] MODE_LEAVE = 2'd2;

	localparam logic [7:0] CHECK_EVEN = 8'haa;
	localparam logic [7:0] CHECK_ODD  = 8'h55;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_DRAW,
		OP_FILL,
		OP_WRITE,
		OP_READ
	} op_t;

	// one queued command: byte walk bounds plus pixel geometry for masks
	typedef struct packed {
		op_t        op;
		logic       chk;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [2:0] p0;
		logic [2:0] p1;
		logic [7:0] xa;
		logic [7:0] xb;
		logic [5:0] ya;
		logic [5:0] yb;
		logic [5:0] y1;
		logic [1:0] fm;
		logic [1:0] em;
		logic [7:0] dat;
		logic       clip;
	} cmd_t;

endpackage

// File: hdl/page_framebuffer_draw_engine_top.sv
// Page frame buffer draw engine, top level: front end, command queue, back end.
// The front end queues each accepted command; the back end walks its bytes, then
// flushes and raises the result; a command that draws nothing skips the walk.
// The queue takes up to two further commands while the back end works; the walk moves one byte per cycle.
// Reset: a clearing sweep writes zero to all PAGES*WIDTH bytes; in_stall is high meanwhile.
module page_framebuffer_draw_engine_top #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] kind,
	input  logic [7:0] col_a,
	input  logic [5:0] row_a,
	input  logic [7:0] col_b,
	input  logic [5:0] row_b,
	input  logic [1:0] fill_mode,
	input  logic [1:0] edge_mode,
	input  logic [1:0] page,
	input  logic [7:0] data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       clipped
);

	pfde_pkg::cmd_t push_cmd, head;
	logic           push, pop, empty, full, busy;

	pfde_front #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.col_a     (col_a),
		.row_a     (row_a),
		.col_b     (col_b),
		.row_b     (row_b),
		.fill_mode (fill_mode),
		.edge_mode (edge_mode),
		.page      (page),
		.data      (data),
		.q_full    (full),
		.busy      (busy),
		.push      (push),
		.cmd       (push_cmd)
	);

	pfde_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	pfde_back #(
		.WIDTH  (WIDTH),
		.HEIGHT (HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.busy      (busy),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data),
		.clipped   (clipped)
	);

endmodule

// File: hdl/pfde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfde_ram #(
	parameter int DW    = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DW-1:0]            wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: hdl/pfde_front.sv
// Front end: accepts command items, clips geometry and builds queue commands.
// Depends on pfde_pkg.
module pfde_front #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          kind,
	input  logic [7:0]          col_a,
	input  logic [5:0]          row_a,
	input  logic [7:0]          col_b,
	input  logic [5:0]          row_b,
	input  logic [1:0]          fill_mode,
	input  logic [1:0]          edge_mode,
	input  logic [1:0]          page,
	input  logic [7:0]          data,
	input  logic                q_full,
	input  logic                busy,
	output logic                push,
	output pfde_pkg::cmd_t      cmd
);

	localparam int         PAGES = (HEIGHT + 7) / 8;
	localparam logic [8:0] W9    = 9'(WIDTH);
	localparam logic [6:0] H7    = 7'(HEIGHT);
	localparam logic [3:0] P4    = 4'(PAGES);

	logic [7:0] x0, x1;
	logic [5:0] y0, y1;
	logic       nonempty, work, byte_ok;

	assign in_stall = q_full | busy;
	assign push     = in_valid & ~in_stall;

	always_comb begin
		x0 = col_a;
		x1 = col_a;
		y0 = row_a;
		y1 = row_a;
		if (kind == pfde_pkg::KIND_HLINE || kind == pfde_pkg::KIND_RECT) begin
			x1 = col_b;
		end
		if (kind == pfde_pkg::KIND_VLINE || kind == pfde_pkg::KIND_RECT) begin
			y1 = row_b;
		end
	end

	assign nonempty = (x0 <= x1) && (y0 <= y1);
	assign work     = nonempty && ({1'b0, x0} < W9) && ({1'b0, y0} < H7);
	assign byte_ok  = ({1'b0, col_a} < W9) && (4'(page) < P4);

	always_comb begin
		cmd     = '0;
		cmd.op  = pfde_pkg::OP_NOP;
		cmd.xa  = col_a;
		cmd.xb  = x1;
		cmd.ya  = row_a;
		cmd.yb  = y1;
		cmd.y1  = ({1'b0, y1} >= H7) ? 6'(HEIGHT - 1) : y1;
		cmd.c0  = x0;
		cmd.c1  = ({1'b0, x1} >= W9) ? 8'(WIDTH - 1) : x1;
		cmd.p0  = 3'(y0 >> 3);
		cmd.p1  = 3'(cmd.y1 >> 3);
		cmd.fm  = fill_mode;
		cmd.em  = pfde_pkg::MODE_LEAVE;
		cmd.dat = data;
		case (kind)
			pfde_pkg::KIND_SET, pfde_pkg::KIND_CLR, pfde_pkg::KIND_HLINE,
			pfde_pkg::KIND_VLINE, pfde_pkg::KIND_RECT: begin
				cmd.clip = nonempty && (({1'b0, x1} >= W9) || ({1'b0, y1} >= H7));
				if (work) begin
					cmd.op = pfde_pkg::OP_DRAW;
				end
				if (kind == pfde_pkg::KIND_SET) begin
					cmd.fm = pfde_pkg::MODE_SET;
				end else if (kind == pfde_pkg::KIND_CLR) begin
					cmd.fm = pfde_pkg::MODE_CLR;
				end else if (kind == pfde_pkg::KIND_RECT) begin
					cmd.em = edge_mode;
				end
			end
			pfde_pkg::KIND_CLEAR, pfde_pkg::KIND_CHECK: begin
				cmd.op  = pfde_pkg::OP_FILL;
				cmd.chk = (kind == pfde_pkg::KIND_CHECK);
				cmd.c0  = '0;
				cmd.c1  = 8'(WIDTH - 1);
				cmd.p0  = '0;
				cmd.p1  = 3'(PAGES - 1);
			end
			pfde_pkg::KIND_WRITE, pfde_pkg::KIND_READ: begin
				cmd.clip = ~byte_ok;
				cmd.c0   = col_a;
				cmd.c1   = col_a;
				cmd.p0   = 3'(page);
				cmd.p1   = 3'(page);
				if (byte_ok) begin
					cmd.op = (kind == pfde_pkg::KIND_WRITE) ? pfde_pkg::OP_WRITE
					                                        : pfde_pkg::OP_READ;
				end
			end
			default: begin
				cmd.op = pfde_pkg::OP_NOP;
			end
		endcase
	end

endmodule

// File: hdl/pfde_queue.sv
// Two-entry command queue between front end and back end.
// Depends on pfde_pkg.
module pfde_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfde_pkg::cmd_t push_cmd,
	input  logic           pop,
	output pfde_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	pfde_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q, rd_ptr_q;
	logic [1:0]     count_q;

	assign head  = ent_q[rd_ptr_q];
	assign empty = (count_q == 2'd0);
	assign full  = (count_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("queue pop while empty");

endmodule

// File: hdl/pfde_back.sv
// Back end: walks the bytes of one command on the frame RAM, one byte per cycle (read-modify-write for draws,
// direct writes for fill and write, reads for read) and holds the result register. Depends on pfde_pkg, pfde_ram.
module pfde_back #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pfde_pkg::cmd_t head,
	input  logic           empty,
	output logic           pop,
	output logic           busy,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     read_data,
	output logic           clipped
);

	localparam int PAGES = (HEIGHT + 7) / 8;
	localparam int DEPTH = PAGES * WIDTH;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH,
		ST_RESP
	} state_t;

	state_t          state_q;
	pfde_pkg::op_t   op_q;
	logic            init_q, chk_q, clip_q;
	logic [7:0]      c_q, c0_q, c1_q, xa_q, xb_q, dat_q, rd_q;
	logic [2:0]      p_q, p1_q;
	logic [5:0]      ya_q, yb_q, y1_q;
	logic [1:0]      fm_q, em_q;

	logic            s1_valid_s1, s1_wr_s1, s1_direct_s1;
	logic [AW-1:0]   addr_s1;
	logic [7:0]      set_s1, clr_s1, dat_s1;

	logic            res_valid_q, res_clip_q;
	logic [7:0]      res_data_q;

	logic [AW-1:0]   addr;
	logic [7:0]      set_m, clr_m, direct_dat, rdata, wdata;
	logic            re, we, last_col, last_page, out_free, direct;

	assign addr       = AW'(32'(p_q) * WIDTH + 32'(c_q));
	assign last_col   = (c_q == c1_q);
	assign last_page  = (p_q == p1_q);
	assign direct     = (op_q == pfde_pkg::OP_FILL) || (op_q == pfde_pkg::OP_WRITE);
	assign direct_dat = (op_q == pfde_pkg::OP_WRITE) ? dat_q :
	                    !chk_q                       ? 8'h00 :
	                    c_q[0]                       ? pfde_pkg::CHECK_ODD
	                                                 : pfde_pkg::CHECK_EVEN;
	assign re         = (state_q == ST_WALK) &&
	                    ((op_q == pfde_pkg::OP_DRAW) || (op_q == pfde_pkg::OP_READ));
	assign we         = s1_valid_s1 && s1_wr_s1;
	assign wdata      = s1_direct_s1 ? dat_s1 : ((rdata & ~clr_s1) | set_s1);
	assign out_free   = !res_valid_q || !out_stall;
	assign pop        = (state_q == ST_IDLE) && !empty;
	assign busy       = init_q;

	assign out_valid  = res_valid_q;
	assign read_data  = res_data_q;
	assign clipped    = res_clip_q;

	// per-pixel mode inside the current byte; on a rect, an edge mode of set or clear overrides fill on edges
	always_comb begin
		logic [5:0] rr;
		logic       in_row, on_edge;
		logic [1:0] md;
		set_m = '0;
		clr_m = '0;
		for (int i = 0; i < 8; i++) begin
			rr      = {p_q, 3'(i)};
			in_row  = (rr >= ya_q) && (rr <= y1_q);
			on_edge = (c_q == xa_q) || (c_q == xb_q) || (rr == ya_q) || (rr == yb_q);
			md      = (on_edge && (em_q == pfde_pkg::MODE_CLR || em_q == pfde_pkg::MODE_SET))
			          ? em_q : fm_q;
			set_m[i] = in_row && (md == pfde_pkg::MODE_SET);
			clr_m[i] = in_row && (md == pfde_pkg::MODE_CLR);
		end
	end

	pfde_ram #(
		.DW    (8),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_s1),
		.wdata (wdata),
		.re    (re),
		.raddr (addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_WALK;
			init_q      <= 1'b1;
			op_q        <= pfde_pkg::OP_FILL;
			chk_q       <= 1'b0;
			c_q         <= '0;
			c0_q        <= '0;
			c1_q        <= 8'(WIDTH - 1);
			p_q         <= '0;
			p1_q        <= 3'(PAGES - 1);
			s1_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			s1_valid_s1 <= (state_q == ST_WALK);
			if (res_valid_q && !out_stall && state_q != ST_RESP) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						op_q   <= head.op;
						chk_q  <= head.chk;
						c_q    <= head.c0;
						c0_q   <= head.c0;
						c1_q   <= head.c1;
						p_q    <= head.p0;
						p1_q   <= head.p1;
						xa_q   <= head.xa;
						xb_q   <= head.xb;
						ya_q   <= head.ya;
						yb_q   <= head.yb;
						y1_q   <= head.y1;
						fm_q   <= head.fm;
						em_q   <= head.em;
						dat_q  <= head.dat;
						clip_q <= head.clip;
						rd_q   <= 8'h00;
						state_q <= (head.op == pfde_pkg::OP_NOP) ? ST_RESP : ST_WALK;
					end
				end
				ST_WALK: begin
					s1_wr_s1     <= (op_q != pfde_pkg::OP_READ);
					s1_direct_s1 <= direct;
					addr_s1      <= addr;
					set_s1       <= set_m;
					clr_s1       <= clr_m;
					dat_s1       <= direct_dat;
					if (last_col) begin
						c_q <= c0_q;
						p_q <= p_q + 3'd1;
						if (last_page) begin
							state_q <= ST_FLUSH;
						end
					end else begin
						c_q <= c_q + 8'd1;
					end
				end
				ST_FLUSH: begin
					rd_q <= (op_q == pfde_pkg::OP_READ) ? rdata : 8'h00;
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						res_data_q  <= rd_q;
						res_clip_q  <= clip_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_no_same_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> (addr_s1 != addr))
		else $error("read and write hit the same byte");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (c_q >= c0_q && c_q <= c1_q && p_q <= p1_q))
		else $error("walk counters outside command range");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_RESP))
		else $error("result raised outside response state");

	a_init_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (!res_valid_q && state_q != ST_IDLE))
		else $error("result or idle during clearing sweep");

endmodule

// File: tb/pfde_reply_checker.sv
// Reply checker for the page frame buffer draw engine: keeps a shadow frame,
// predicts one reply per accepted command and compares replies in order.
// Depends on pfde_pkg for command codes, draw modes and checkerboard bytes.
module pfde_reply_checker #(
	parameter int WIDTH  = 128,
	parameter int HEIGHT = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [3:0] kind,
	input  logic [7:0] col_a,
	input  logic [5:0] row_a,
	input  logic [7:0] col_b,
	input  logic [5:0] row_b,
	input  logic [1:0] fill_mode,
	input  logic [1:0] edge_mode,
	input  logic [1:0] page,
	input  logic [7:0] data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [7:0] read_data,
	input  logic       clipped,
	output int         mismatches,
	output int         outstanding,
	output int         commands_seen,
	output int         replies_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAGES        = (HEIGHT + 7) / 8;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] read_data;
		logic       clipped;
	} reply_t;

	logic [7:0] shadow_frame [PAGES][WIDTH];
	reply_t     due_replies [$];
	int         errors;

	// returns 1 when the pixel falls outside the frame
	function automatic logic paint(input int x, input int y, input logic [1:0] mode);
		if (x >= WIDTH || y >= HEIGHT)
			return 1'b1;
		if (mode == pfde_pkg::MODE_CLR)
			shadow_frame[y / 8][x][y % 8] = 1'b0;
		else if (mode == pfde_pkg::MODE_SET)
			shadow_frame[y / 8][x][y % 8] = 1'b1;
		return 1'b0;
	endfunction

	function automatic reply_t render_command(
		input logic [3:0] k,
		input logic [7:0] ca,
		input logic [5:0] ra,
		input logic [7:0] cb,
		input logic [5:0] rb,
		input logic [1:0] fm,
		input logic [1:0] em,
		input logic [1:0] pg,
		input logic [7:0] d
	);
		reply_t     r;
		logic [1:0] m;
		logic       on_rim;
		r = '0;
		case (k)
		pfde_pkg::KIND_SET: begin
			r.clipped = paint(int'(ca), int'(ra), pfde_pkg::MODE_SET);
		end
		pfde_pkg::KIND_CLR: begin
			r.clipped = paint(int'(ca), int'(ra), pfde_pkg::MODE_CLR);
		end
		pfde_pkg::KIND_HLINE: begin
			for (int x = int'(ca); x <= int'(cb); x++)
				r.clipped |= paint(x, int'(ra), fm);
		end
		pfde_pkg::KIND_VLINE: begin
			for (int y = int'(ra); y <= int'(rb); y++)
				r.clipped |= paint(int'(ca), y, fm);
		end
		pfde_pkg::KIND_RECT: begin
			if (ca <= cb && ra <= rb) begin
				for (int y = int'(ra); y <= int'(rb); y++)
					for (int x = int'(ca); x <= int'(cb); x++) begin
						on_rim = (x == ca || x == cb || y == ra || y == rb);
						m = (on_rim && em <= pfde_pkg::MODE_SET) ? em : fm;
						r.clipped |= paint(x, y, m);
					end
			end
		end
		pfde_pkg::KIND_CLEAR: begin
			foreach (shadow_frame[p, x])
				shadow_frame[p][x] = '0;
		end
		pfde_pkg::KIND_CHECK: begin
			foreach (shadow_frame[p, x])
				shadow_frame[p][x] = (x % 2) ? pfde_pkg::CHECK_ODD : pfde_pkg::CHECK_EVEN;
		end
		pfde_pkg::KIND_WRITE: begin
			if (ca < WIDTH && pg < PAGES)
				shadow_frame[pg][ca] = d;
			else
				r.clipped = 1'b1;
		end
		pfde_pkg::KIND_READ: begin
			if (ca < WIDTH && pg < PAGES)
				r.read_data = shadow_frame[pg][ca];
			else
				r.clipped = 1'b1;
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic flag(input string msg);
		errors++;
		if (errors <= REPORT_LIMIT)
			$display("%0t ns: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		if (!arst_n) begin
			foreach (shadow_frame[p, x])
				shadow_frame[p][x] = '0;
			due_replies.delete();
			errors = 0;
			mismatches <= 0;
			outstanding <= 0;
			commands_seen <= 0;
			replies_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				replies_seen <= replies_seen + 1;
				if (due_replies.size() == 0) begin
					flag($sformatf("reply %0d with no command pending: read_data %02h clipped %b",
						replies_seen, read_data, clipped));
				end else begin
					want = due_replies.pop_front();
					if (read_data !== want.read_data)
						flag($sformatf("reply %0d: read_data expected %02h, got %02h",
							replies_seen, want.read_data, read_data));
					if (clipped !== want.clipped)
						flag($sformatf("reply %0d: clipped expected %b, got %b",
							replies_seen, want.clipped, clipped));
				end
			end
			if (in_valid && !in_stall) begin
				due_replies.push_back(render_command(kind, col_a, row_a, col_b, row_b,
					fill_mode, edge_mode, page, data));
				commands_seen <= commands_seen + 1;
			end
			mismatches <= errors;
			outstanding <= due_replies.size();
		end
	end

endmodule

// File: tb/tb_page_framebuffer_draw_engine_top.sv
// Testbench top for the page frame buffer draw engine: directed and random
// drawing commands under three pacing phases, checked by pfde_reply_checker.
// Depends on pfde_pkg, page_framebuffer_draw_engine_top and pfde_reply_checker.
module tb_page_framebuffer_draw_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH            = 128;
	localparam int HEIGHT           = 32;
	localparam int RANDOM_PER_PHASE = 382;
	localparam int DRAIN_LIMIT      = 20000;
	localparam int TAIL_CYCLES      = 20;

	localparam logic [3:0] KIND_SPARE = pfde_pkg::KIND_READ + 4'd1;
	localparam logic [3:0] KIND_TOP   = 4'hf;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       out_stall = 1'b0;
	logic [3:0] kind      = '0;
	logic [7:0] col_a     = '0;
	logic [5:0] row_a     = '0;
	logic [7:0] col_b     = '0;
	logic [5:0] row_b     = '0;
	logic [1:0] fill_mode = '0;
	logic [1:0] edge_mode = '0;
	logic [1:0] page      = '0;
	logic [7:0] data      = '0;
	wire        in_stall;
	wire        out_valid;
	wire  [7:0] read_data;
	wire        clipped;

	int send_idle_pct = 36;
	int recv_idle_pct = 50;
	int sent          = 0;
	int directed_sent = 0;
	int mismatches;
	int outstanding;
	int commands_seen;
	int replies_seen;

	page_framebuffer_draw_engine_top #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.col_a    (col_a),
		.row_a    (row_a),
		.col_b    (col_b),
		.row_b    (row_b),
		.fill_mode(fill_mode),
		.edge_mode(edge_mode),
		.page     (page),
		.data     (data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.clipped  (clipped)
	);

	pfde_reply_checker #(
		.WIDTH (WIDTH),
		.HEIGHT(HEIGHT)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.col_a        (col_a),
		.row_a        (row_a),
		.col_b        (col_b),
		.row_b        (row_b),
		.fill_mode    (fill_mode),
		.edge_mode    (edge_mode),
		.page         (page),
		.data         (data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_data    (read_data),
		.clipped      (clipped),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.commands_seen(commands_seen),
		.replies_seen (replies_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	task automatic issue(
		input logic [3:0] k,
		input logic [7:0] ca,
		input logic [5:0] ra,
		input logic [7:0] cb,
		input logic [5:0] rb,
		input logic [1:0] fm,
		input logic [1:0] em,
		input logic [1:0] pg,
		input logic [7:0] d
	);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		kind      <= k;
		col_a     <= ca;
		row_a     <= ra;
		col_b     <= cb;
		row_b     <= rb;
		fill_mode <= fm;
		edge_mode <= em;
		page      <= pg;
		data      <= d;
		do
			@(posedge clk);
		while (in_stall);
		sent++;
	endtask

	// mostly inside the frame, sometimes anywhere the field reaches
	function automatic logic [7:0] pick_col();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, WIDTH - 1));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [5:0] pick_row();
		if ($urandom_range(0, 99) < 85)
			return 6'($urandom_range(0, HEIGHT - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	function automatic logic [7:0] stretch_col(input logic [7:0] base);
		int v;
		if ($urandom_range(0, 19) == 0)
			return 8'($urandom_range(0, 255));
		v = base + $urandom_range(0, 12);
		return (v > 255) ? 8'd255 : 8'(v);
	endfunction

	function automatic logic [5:0] stretch_row(input logic [5:0] base);
		int v;
		if ($urandom_range(0, 19) == 0)
			return 6'($urandom_range(0, 63));
		v = base + $urandom_range(0, 6);
		return (v > 63) ? 6'd63 : 6'(v);
	endfunction

	task automatic issue_random();
		int         roll;
		logic [3:0] k;
		logic [7:0] ca;
		logic [5:0] ra;
		roll = $urandom_range(0, 99);
		ca = pick_col();
		ra = pick_row();
		if (roll < 12)
			k = pfde_pkg::KIND_SET;
		else if (roll < 20)
			k = pfde_pkg::KIND_CLR;
		else if (roll < 32)
			k = pfde_pkg::KIND_HLINE;
		else if (roll < 44)
			k = pfde_pkg::KIND_VLINE;
		else if (roll < 56)
			k = pfde_pkg::KIND_RECT;
		else if (roll < 57)
			k = pfde_pkg::KIND_CLEAR;
		else if (roll < 58)
			k = pfde_pkg::KIND_CHECK;
		else if (roll < 70)
			k = pfde_pkg::KIND_WRITE;
		else if (roll < 96)
			k = pfde_pkg::KIND_READ;
		else
			k = 4'($urandom_range(KIND_SPARE, KIND_TOP));
		issue(k, ca, ra, stretch_col(ca), stretch_row(ra), 2'($urandom_range(0, 3)),
			2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	initial begin : stimulus
		int waited;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, clipping, empty ranges, modes, whole-frame ops
		issue(pfde_pkg::KIND_READ, 8'd0, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_SET, 8'd0, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_SET, 8'(WIDTH - 1), 6'(HEIGHT - 1), 8'd0, 6'd0,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_SET, 2'd3, 8'hff);
		issue(pfde_pkg::KIND_SET, 8'd255, 6'd63, 8'd255, 6'd63,
			pfde_pkg::MODE_LEAVE, pfde_pkg::MODE_LEAVE, 2'd1, 8'h81);
		issue(pfde_pkg::KIND_CLR, 8'(WIDTH - 1), 6'(HEIGHT - 1), 8'd0, 6'd0,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_SET, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_SET, 8'(WIDTH), 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_HLINE, 8'd0, 6'd5, 8'd255, 6'd0,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_HLINE, 8'd40, 6'd7, 8'd39, 6'd0,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_HLINE, 8'd0, 6'(HEIGHT - 1), 8'(WIDTH - 1), 6'd0,
			2'd3, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_VLINE, 8'd3, 6'd0, 8'd0, 6'd63,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_SET, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_VLINE, 8'(WIDTH - 1), 6'd20, 8'd0, 6'd10,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_SET, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_RECT, 8'd10, 6'd2, 8'd20, 6'd9,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_RECT, 8'd30, 6'd2, 8'd25, 6'd9,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_SET, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_RECT, 8'd12, 6'd4, 8'd18, 6'd7,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_LEAVE, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_RECT, 8'd100, 6'd28, 8'd200, 6'd40,
			pfde_pkg::MODE_SET, 2'd3, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_READ, 8'd10, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_READ, 8'd15, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd1, 8'h00);
		issue(pfde_pkg::KIND_CHECK, 8'd0, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_READ, 8'd1, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd3, 8'h00);
		issue(pfde_pkg::KIND_WRITE, 8'(WIDTH - 1), 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd3, 8'hff);
		issue(pfde_pkg::KIND_WRITE, 8'(WIDTH), 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h5a);
		issue(pfde_pkg::KIND_READ, 8'(WIDTH - 1), 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd3, 8'h00);
		issue(pfde_pkg::KIND_READ, 8'd255, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd3, 8'h00);
		issue(KIND_TOP, 8'd5, 6'd5, 8'd9, 6'd9,
			pfde_pkg::MODE_SET, pfde_pkg::MODE_SET, 2'd2, 8'h33);
		issue(pfde_pkg::KIND_CLEAR, 8'd0, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		issue(pfde_pkg::KIND_READ, 8'd0, 6'd0, 8'd0, 6'd0,
			pfde_pkg::MODE_CLR, pfde_pkg::MODE_CLR, 2'd0, 8'h00);
		directed_sent = sent;

		repeat (RANDOM_PER_PHASE) issue_random();
		send_idle_pct <= 50;
		recv_idle_pct <= 36;
		repeat (RANDOM_PER_PHASE) issue_random();
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		repeat (RANDOM_PER_PHASE) issue_random();

		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (outstanding != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d drawing commands (%0d directed, rest random in three pacing phases)",
			sent, directed_sent);
		$display("Checked %0d replies for %0d accepted commands; %0d failures, %0d missing",
			replies_seen, commands_seen, mismatches, outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
